FILE: sv/hsdk_pkg.sv
package hsdk_pkg;

  // key ring depth, legal range 2 to 64
  localparam int KEY_LEN   = 20;
  localparam int ADDR_W    = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int CNT_W     = $clog2(KEY_LEN + 1);
  localparam int HDR_BYTES = 8;
  localparam int HDR_W     = 8 * HDR_BYTES;
  localparam int LEN_W     = 4;
  localparam int PLEN_W    = 16;
  localparam int SEL_W     = $clog2(HDR_BYTES);

  localparam logic [LEN_W-1:0]  HL_RESET  = LEN_W'(4);
  localparam logic [LEN_W-1:0]  HL_MAX    = LEN_W'(HDR_BYTES);
  localparam logic [LEN_W-1:0]  LEARN_CNT = LEN_W'(2);
  localparam logic [PLEN_W-1:0] LEN_BIAS  = PLEN_W'(2);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic walk_start;
    logic walk_dec;
    logic walk_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic wr_done;
    logic first;
    logic all_ok;
    logic pair_known;
    logic walk_done;
    logic out_free;
  } sts_t;

  function automatic addr_t ring_next(input addr_t a);
    return (a == addr_t'(KEY_LEN - 1)) ? '0 : a + addr_t'(1);
  endfunction

  function automatic addr_t ring_prev(input addr_t a);
    return (a == '0) ? addr_t'(KEY_LEN - 1) : a - addr_t'(1);
  endfunction

endpackage

FILE: sv/hsdk_ctrl.sv
module hsdk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsdk_pkg::sts_t    sts,
  output hsdk_pkg::cmd_t    cmd
);

  hsdk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsdk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hsdk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hsdk_pkg::ST_WRITE;
        end
      end
      hsdk_pkg::ST_WRITE: begin
        if (!sts.wr_done) begin
          cmd.wr_en = 1'b1;
        end else if (sts.first) begin
          state_nxt = hsdk_pkg::ST_DONE;
        end else if (sts.all_ok) begin
          cmd.walk_start = 1'b1;
          cmd.walk_dec   = 1'b1;
          state_nxt      = hsdk_pkg::ST_WALK;
        end else if (!sts.pair_known) begin
          cmd.walk_start = 1'b1;
          state_nxt      = hsdk_pkg::ST_WALK;
        end else begin
          state_nxt = hsdk_pkg::ST_DONE;
        end
      end
      hsdk_pkg::ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_done) begin
          state_nxt = hsdk_pkg::ST_DONE;
        end
      end
      hsdk_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = hsdk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hsdk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/hsdk_dpath.sv
module hsdk_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsdk_pkg::cmd_t                cmd,
  output hsdk_pkg::sts_t                sts,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsdk_pkg::LEN_W-1:0]    cfg_header_length,
  input  logic [hsdk_pkg::HDR_W-1:0]    in_header_bytes,
  input  logic [hsdk_pkg::PLEN_W-1:0]   in_packet_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsdk_pkg::HDR_W-1:0]    out_header_out,
  output logic                          out_decrypted,
  output logic                          out_key_learned,
  output logic                          out_whole_key
);

  // configuration
  logic [hsdk_pkg::LEN_W-1:0] hl_r;

  // rings: cipher and key as memories, valid and known marks as flops
  logic [7:0]                  cmem [hsdk_pkg::KEY_LEN];
  logic [7:0]                  kmem [hsdk_pkg::KEY_LEN];
  logic [hsdk_pkg::KEY_LEN-1:0] cvld_r;
  logic [hsdk_pkg::KEY_LEN-1:0] known_r;
  logic [hsdk_pkg::CNT_W-1:0]  cnt_r;

  // per-stream state
  hsdk_pkg::addr_t pos_r;
  logic            first_r;

  // per-item registers
  logic [hsdk_pkg::HDR_BYTES-1:0][7:0] res_r;
  logic [hsdk_pkg::PLEN_W-1:0]         plen_r;
  logic [hsdk_pkg::LEN_W-1:0]          len_r;
  logic [hsdk_pkg::LEN_W-1:0]          k_r;
  hsdk_pkg::addr_t                     idx_r;
  logic                                all_ok_r;
  logic                                dec_r;
  logic                                lrn_r;

  // walk over the ring
  hsdk_pkg::addr_t             ridx_r;
  hsdk_pkg::addr_t             aaddr_r;
  logic [hsdk_pkg::LEN_W-1:0]  j_r;
  logic [hsdk_pkg::LEN_W-1:0]  aj_r;
  logic [hsdk_pkg::LEN_W-1:0]  n_r;
  logic                        vp_r;
  logic [7:0]                  prev_r;
  logic [7:0]                  cdat_q;
  logic                        cvld_q;
  logic [7:0]                  kdat_q;

  // output register
  logic                        out_valid_r;
  logic [hsdk_pkg::HDR_W-1:0]  out_hdr_r;
  logic                        out_dec_r;
  logic                        out_lrn_r;
  logic                        out_whole_r;

  logic [7:0]                  c_byte;
  logic [7:0]                  mix;
  logic [hsdk_pkg::PLEN_W-1:0] pl_v;
  logic [7:0]                  plain_byte;
  logic [hsdk_pkg::SEL_W-1:0]  bsel;
  logic                        issue;
  logic                        arrive;

  assign cfg_ready = 1'b1;

  assign c_byte     = cvld_q ? cdat_q : 8'h00;
  assign mix        = c_byte - prev_r;
  assign pl_v       = plen_r - hsdk_pkg::LEN_BIAS;
  assign plain_byte = (aj_r == hsdk_pkg::LEN_W'(1)) ? pl_v[15:8] : pl_v[7:0];
  assign bsel       = hsdk_pkg::SEL_W'(aj_r - hsdk_pkg::LEN_W'(1));
  assign issue      = cmd.walk_en && (j_r <= n_r);
  assign arrive     = cmd.walk_en && vp_r && (aj_r != '0);

  assign sts.wr_done    = (k_r == len_r);
  assign sts.first      = first_r;
  assign sts.all_ok     = all_ok_r;
  assign sts.pair_known = known_r[pos_r] & known_r[hsdk_pkg::ring_next(pos_r)];
  assign sts.walk_done  = vp_r && (aj_r == n_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r        <= hsdk_pkg::HL_RESET;
      cvld_r      <= '0;
      known_r     <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      first_r     <= 1'b1;
      vp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hl_r <= cfg_header_length;
      end
      if (cmd.wr_en) begin
        cvld_r[idx_r] <= 1'b1;
      end
      if (arrive && !dec_r) begin
        known_r[aaddr_r] <= 1'b1;
        if (!known_r[aaddr_r]) begin
          cnt_r <= cnt_r + hsdk_pkg::CNT_W'(1);
        end
      end
      if (cmd.walk_start) begin
        vp_r <= 1'b0;
      end else if (cmd.walk_en) begin
        vp_r <= issue;
      end
      if (cmd.finish) begin
        pos_r       <= idx_r;
        first_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      cmem[idx_r] <= res_r[k_r[hsdk_pkg::SEL_W-1:0]];
    end
    if (arrive && !dec_r) begin
      kmem[aaddr_r] <= plain_byte ^ mix;
    end
    cdat_q <= cmem[ridx_r];
    cvld_q <= cvld_r[ridx_r];
    kdat_q <= kmem[ridx_r];
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r    <= in_header_bytes;
      plen_r   <= in_packet_length;
      len_r    <= (hl_r > hsdk_pkg::HL_MAX) ? hsdk_pkg::HL_MAX : hl_r;
      k_r      <= '0;
      idx_r    <= pos_r;
      all_ok_r <= 1'b1;
      dec_r    <= 1'b0;
      lrn_r    <= 1'b0;
    end
    if (cmd.wr_en) begin
      all_ok_r <= all_ok_r & known_r[idx_r];
      idx_r    <= hsdk_pkg::ring_next(idx_r);
      k_r      <= k_r + hsdk_pkg::LEN_W'(1);
    end
    if (cmd.walk_start) begin
      dec_r  <= cmd.walk_dec;
      lrn_r  <= !cmd.walk_dec;
      n_r    <= cmd.walk_dec ? len_r : hsdk_pkg::LEARN_CNT;
      j_r    <= '0;
      ridx_r <= hsdk_pkg::ring_prev(pos_r);
    end else if (issue) begin
      aaddr_r <= ridx_r;
      aj_r    <= j_r;
      ridx_r  <= hsdk_pkg::ring_next(ridx_r);
      j_r     <= j_r + hsdk_pkg::LEN_W'(1);
    end
    if (cmd.walk_en && vp_r) begin
      prev_r <= c_byte;
    end
    if (arrive && dec_r) begin
      res_r[bsel] <= kdat_q ^ mix;
    end
    if (cmd.finish) begin
      out_hdr_r   <= res_r;
      out_dec_r   <= dec_r;
      out_lrn_r   <= lrn_r;
      out_whole_r <= (cnt_r == hsdk_pkg::CNT_W'(hsdk_pkg::KEY_LEN));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_header_out  = out_hdr_r;
  assign out_decrypted   = out_dec_r;
  assign out_key_learned = out_lrn_r;
  assign out_whole_key   = out_whole_r;

endmodule

FILE: sv/header_stream_decrypt_key_recovery.sv
// flow: L header bytes go to the cipher ring, L the header length (capped at 8);
//   unless the header is only stored or nothing is learned, a walk handles n ring
//   bytes, n = L when decrypting, 2 when learning; then the result is registered
// throughput: one header at a time; the next is taken when the sequencer is idle;
//   ring bytes move one per cycle through one read port of each ring memory
// reset: synchronous active-low rst_n clears rings' valid and known marks, position,
//   first-header flag and header length (back to 4); no clearing pass needed
module header_stream_decrypt_key_recovery (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: header length
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsdk_pkg::LEN_W-1:0]    cfg_header_length,
  // encrypted header in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsdk_pkg::HDR_W-1:0]    in_header_bytes,
  input  logic [hsdk_pkg::PLEN_W-1:0]   in_packet_length,
  // result out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsdk_pkg::HDR_W-1:0]    out_header_out,
  output logic                          out_decrypted,
  output logic                          out_key_learned,
  output logic                          out_whole_key
);

  // command and status between sequencer and datapath
  hsdk_pkg::cmd_t cmd;
  hsdk_pkg::sts_t sts;

  // sequencer: idle, write cipher bytes, walk the ring, hand off result
  hsdk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: rings, key check, decrypt or learn walk, output register
  // the output register lets the sequencer go idle while a result waits
  hsdk_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_header_length (cfg_header_length),
    .in_header_bytes   (in_header_bytes),
    .in_packet_length  (in_packet_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_header_out    (out_header_out),
    .out_decrypted     (out_decrypted),
    .out_key_learned   (out_key_learned),
    .out_whole_key     (out_whole_key)
  );

endmodule
